FILE: rtl/core/dmr_pkg.sv
package dmr_pkg;

    localparam int K_W        = 20;
    localparam int K_SHIFT    = 4;
    localparam int CONC_W     = 32;
    localparam int Q16_W      = 16;
    localparam int RATE_W     = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;
    // k (Q8.24) plus a concentration
    localparam int DEN_W      = CONC_W + 1;
    // one quotient bit per stage, the top bit only marks saturation
    localparam int DIV_STAGES = Q16_W + 1;
    localparam int POST_DIV   = 10;
    localparam int LATENCY    = DIV_STAGES + POST_DIV;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUBSTRATE_K = 3'd0,
        CFG_OXYGEN_K    = 3'd1,
        CFG_NOX_K       = 3'd2,
        CFG_MAX_GROWTH  = 3'd3,
        CFG_YIELD       = 3'd4,
        CFG_ANOXIC      = 3'd5,
        CFG_DECAY       = 3'd6,
        CFG_N_FRACTION  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CO_IDLE,
        CO_PREP,
        CO_LOAD,
        CO_RUN
    } coef_state_t;

    typedef enum logic [2:0] {
        SEL_S1,
        SEL_S23,
        SEL_O,
        SEL_A,
        SEL_B
    } coef_sel_t;

    typedef struct packed {
        logic [CONC_W-1:0] substrate_conc;
        logic [CONC_W-1:0] oxygen_conc;
        logic [CONC_W-1:0] nitrate_conc;
        logic [CONC_W-1:0] nitrite_conc;
        logic [CONC_W-1:0] nitric_oxide_conc;
        logic [CONC_W-1:0] biomass_density;
        logic              in_domain;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] substrate_uptake;
        logic signed [OUT_W-1:0] oxygen_uptake;
        logic signed [OUT_W-1:0] nitrate_uptake;
        logic signed [OUT_W-1:0] nitrite_uptake;
        logic signed [OUT_W-1:0] nitric_oxide_uptake;
        logic signed [OUT_W-1:0] nitrogen_uptake;
        logic signed [OUT_W-1:0] net_growth_rate;
    } out_word_t;

endpackage

FILE: rtl/core/dmr_frac_div.sv
module dmr_frac_div (
    input  logic                              clk,
    input  logic [dmr_pkg::CONC_W-1:0]        num,
    input  logic [dmr_pkg::DEN_W-1:0]         den,
    output logic [dmr_pkg::Q16_W-1:0]         quo
);

    localparam int NS = dmr_pkg::DIV_STAGES;
    localparam int DW = dmr_pkg::DEN_W;

    logic [DW-1:0] rem_reg [NS];
    logic [DW-1:0] den_reg [NS];
    logic [NS-1:0] quo_reg [NS];

    logic [DW-1:0] den_eff;
    logic [DW-1:0] num_ext;
    logic          first_q;

    // a zero divisor only comes with a zero dividend; an all-ones divisor then gives 0
    always_comb
    begin
        den_eff = (den == '0) ? '1 : den;
        num_ext = DW'(num);
        first_q = (num_ext >= den_eff);
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den_eff;
        rem_reg[0] <= first_q ? DW'(num_ext - den_eff) : num_ext;
        quo_reg[0] <= NS'(first_q);
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_step
        logic [DW:0] shl;
        logic        qb;

        always_comb
        begin
            shl = {rem_reg[k-1], 1'b0};
            qb  = (shl >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= qb ? DW'(shl - {1'b0, den_reg[k-1]}) : shl[DW-1:0];
            quo_reg[k] <= {quo_reg[k-1][NS-2:0], qb};
        end
    end

    // quotient of 1.0 saturates
    assign quo = quo_reg[NS-1][NS-1] ? '1 : quo_reg[NS-1][NS-2:0];

endmodule

FILE: rtl/core/denitrification_monod_rates_core.sv
// done strobes once for each accepted word; one word per cycle while busy is low
// the 17-stage divider pipeline sets most of the latency, 10 multiply and saturate stages follow
// busy is high after reset and after each write to the yield or anoxic configuration registers,
// while one shared radix-2 divider recomputes the five stoichiometric coefficients
// reset clears the configuration registers to their defaults and the valid pipeline; results cannot be stalled
module denitrification_monod_rates_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dmr_pkg::in_word_t                 item,
    output logic                              done,
    output dmr_pkg::out_word_t                result,
    input  logic                              cfg_we,
    input  logic [dmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NUM_DIV = 9;
    localparam int F_S1 = 0;
    localparam int F_O1 = 1;
    localparam int F_S2 = 2;
    localparam int F_N3 = 3;
    localparam int F_O2 = 4;
    localparam int F_S3 = 5;
    localparam int F_N2 = 6;
    localparam int F_O3 = 7;
    localparam int F_NO = 8;

    localparam int CW      = dmr_pkg::CONC_W;
    localparam int DW      = dmr_pkg::DEN_W;
    localparam int QW      = dmr_pkg::Q16_W;
    localparam int RW      = dmr_pkg::RATE_W;
    localparam int KW      = dmr_pkg::K_W;
    localparam int KQW     = KW + dmr_pkg::K_SHIFT;
    localparam int NS      = dmr_pkg::DIV_STAGES;
    localparam int LAT     = dmr_pkg::LATENCY;
    localparam int COEF_W  = 49;
    localparam int CHI_W   = COEF_W - QW;
    localparam int V_W     = 34;
    localparam int PLO_W   = V_W + QW;
    localparam int PHI_W   = V_W + CHI_W;
    localparam int TW      = 31;
    localparam int CDIV_W  = 64;
    localparam int STEP_W  = $clog2(CDIV_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CDIV_W - 1);
    localparam logic [CDIV_W-1:0] MILLE     = 64'd1000;
    localparam logic [CDIV_W-1:0] A_DIV     = 64'd1143;
    localparam logic [CDIV_W-1:0] B_DIV     = 64'd571;
    localparam logic [TW-1:0]     TCAP      = '1;

    function automatic logic [KQW-1:0] k_slot(input logic [3*KW-1:0] packed_k, input int slot);
        return {packed_k[slot*KW +: KW], {dmr_pkg::K_SHIFT{1'b0}}};
    endfunction

    function automatic logic [RW-1:0] mul_q16(input logic [RW-1:0] a, input logic [QW-1:0] f);
        logic [RW+QW-1:0] p;
        p = (RW+QW)'(a) * (RW+QW)'(f);
        return p[RW+QW-1:QW];
    endfunction

    function automatic logic [RW-1:0] mul_x(input logic [RW-1:0] r, input logic [CW-1:0] x);
        logic [RW+CW-1:0] p;
        p = (RW+CW)'(r) * (RW+CW)'(x);
        return p[RW+CW-1:CW];
    endfunction

    function automatic logic [TW-1:0] term_sat(input logic [PHI_W-1:0] phi,
                                               input logic [PLO_W-1:0] plo);
        logic [PHI_W:0] s;
        s = (PHI_W+1)'(phi) + (PHI_W+1)'(plo[PLO_W-1:QW]);
        return (s > (PHI_W+1)'(TCAP)) ? TCAP : s[TW-1:0];
    endfunction

    // configuration registers
    logic [3*KW-1:0] ks_reg, ko_reg, kn_reg;
    logic [RW-1:0]   mu_reg, decay_reg;
    logic [QW-1:0]   yield_reg, nfrac_reg;
    logic [3*QW-1:0] anox_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg    <= '0;
            ko_reg    <= '0;
            kn_reg    <= '0;
            mu_reg    <= '0;
            yield_reg <= '1;
            anox_reg  <= '0;
            decay_reg <= '0;
            nfrac_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (dmr_pkg::cfg_idx_t'(cfg_index))
                dmr_pkg::CFG_SUBSTRATE_K: ks_reg    <= cfg_data[3*KW-1:0];
                dmr_pkg::CFG_OXYGEN_K:    ko_reg    <= cfg_data[3*KW-1:0];
                dmr_pkg::CFG_NOX_K:       kn_reg    <= cfg_data[3*KW-1:0];
                dmr_pkg::CFG_MAX_GROWTH:  mu_reg    <= cfg_data[RW-1:0];
                dmr_pkg::CFG_YIELD:       yield_reg <= cfg_data[QW-1:0];
                dmr_pkg::CFG_ANOXIC:      anox_reg  <= cfg_data[3*QW-1:0];
                dmr_pkg::CFG_DECAY:       decay_reg <= cfg_data[RW-1:0];
                dmr_pkg::CFG_N_FRACTION:  nfrac_reg <= cfg_data[QW-1:0];
            endcase
        end
    end

    // coefficient engine: one restoring divider, one quotient bit per cycle in the run state
    dmr_pkg::coef_state_t co_state_reg, co_state_next;
    dmr_pkg::coef_sel_t   sel_reg, sel_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 coef_wr;
    logic [2*QW-1:0]      ye_reg;
    logic [CDIV_W-1:0]    co_num_reg, co_den_reg, co_rem_reg, co_quo_reg;
    logic [CDIV_W-1:0]    ld_num, ld_den, a_num;
    logic [CDIV_W:0]      co_rem2;
    logic                 co_qb;
    logic [CDIV_W-1:0]    co_rem_next, co_quo_full;
    logic [COEF_W-1:0]    coef_val;
    logic [COEF_W-1:0]    c_s1_reg, c_s23_reg, c_o_reg, c_a_reg, c_b_reg;
    logic                 restart;

    assign restart = cfg_we && (cfg_index == dmr_pkg::CFG_YIELD ||
                                cfg_index == dmr_pkg::CFG_ANOXIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_state_reg <= dmr_pkg::CO_PREP;
            sel_reg      <= dmr_pkg::SEL_S1;
            step_reg     <= '0;
        end
        else
        begin
            co_state_reg <= co_state_next;
            sel_reg      <= sel_next;
            step_reg     <= step_next;
        end
    end

    always_comb
    begin
        co_state_next = co_state_reg;
        sel_next      = sel_reg;
        step_next     = step_reg;
        coef_wr       = 1'b0;
        unique case (co_state_reg)
            dmr_pkg::CO_IDLE:
            begin
                co_state_next = dmr_pkg::CO_IDLE;
            end
            dmr_pkg::CO_PREP:
            begin
                co_state_next = dmr_pkg::CO_LOAD;
                sel_next      = dmr_pkg::SEL_S1;
            end
            dmr_pkg::CO_LOAD:
            begin
                co_state_next = dmr_pkg::CO_RUN;
                step_next     = '0;
            end
            dmr_pkg::CO_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    coef_wr   = 1'b1;
                    step_next = '0;
                    if (sel_reg == dmr_pkg::SEL_B)
                    begin
                        co_state_next = dmr_pkg::CO_IDLE;
                    end
                    else
                    begin
                        sel_next      = dmr_pkg::coef_sel_t'(sel_reg + 3'd1);
                        co_state_next = dmr_pkg::CO_LOAD;
                    end
                end
            end
        endcase
        if (restart)
        begin
            co_state_next = dmr_pkg::CO_PREP;
        end
    end

    always_comb
    begin
        a_num  = ((CDIV_W'(33'h1_0000_0000) - CDIV_W'(ye_reg)) * MILLE) << QW;
        ld_num = '0;
        ld_den = '0;
        unique case (sel_reg)
            dmr_pkg::SEL_S1:
            begin
                ld_num = CDIV_W'(1) << 32;
                ld_den = CDIV_W'(yield_reg);
            end
            dmr_pkg::SEL_S23:
            begin
                ld_num = CDIV_W'(1) << 48;
                ld_den = CDIV_W'(ye_reg);
            end
            dmr_pkg::SEL_O:
            begin
                ld_num = (CDIV_W'(17'h1_0000) - CDIV_W'(yield_reg)) << QW;
                ld_den = CDIV_W'(yield_reg);
            end
            dmr_pkg::SEL_A:
            begin
                ld_num = a_num;
                ld_den = A_DIV * CDIV_W'(ye_reg);
            end
            dmr_pkg::SEL_B:
            begin
                ld_num = a_num;
                ld_den = B_DIV * CDIV_W'(ye_reg);
            end
            default:
            begin
                ld_num = '0;
                ld_den = '0;
            end
        endcase
    end

    always_comb
    begin
        co_rem2     = {co_rem_reg, co_num_reg[CDIV_W-1]};
        co_qb       = (co_rem2 >= {1'b0, co_den_reg});
        co_rem_next = co_qb ? CDIV_W'(co_rem2 - {1'b0, co_den_reg}) : co_rem2[CDIV_W-1:0];
        co_quo_full = {co_quo_reg[CDIV_W-2:0], co_qb};
        coef_val    = (co_den_reg == '0) ? '0 : co_quo_full[COEF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        ye_reg <= (2*QW)'(yield_reg) * (2*QW)'(anox_reg[3*QW-1:2*QW]);
        if (co_state_reg == dmr_pkg::CO_LOAD)
        begin
            co_num_reg <= ld_num;
            co_den_reg <= ld_den;
            co_rem_reg <= '0;
            co_quo_reg <= '0;
        end
        else if (co_state_reg == dmr_pkg::CO_RUN)
        begin
            co_num_reg <= co_num_reg << 1;
            co_rem_reg <= co_rem_next;
            co_quo_reg <= co_quo_full;
        end
        if (coef_wr)
        begin
            unique case (sel_reg)
                dmr_pkg::SEL_S1:  c_s1_reg  <= coef_val;
                dmr_pkg::SEL_S23: c_s23_reg <= coef_val;
                dmr_pkg::SEL_O:   c_o_reg   <= coef_val;
                dmr_pkg::SEL_A:   c_a_reg   <= coef_val;
                dmr_pkg::SEL_B:   c_b_reg   <= coef_val;
                default:          ;
            endcase
        end
    end

    assign busy = (co_state_reg != dmr_pkg::CO_IDLE);

    // valid pipeline
    logic           accept;
    logic [LAT-1:0] valid_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
        end
    end

    assign done = valid_reg[LAT-1];

    // monod and inhibition factors
    logic [CW-1:0] div_num [NUM_DIV];
    logic [DW-1:0] div_den [NUM_DIV];
    logic [QW-1:0] fac [NUM_DIV];
    logic [KQW-1:0] ks1, ks2, ks3, ko1, ko2, ko3, kn3, kn2, kno;

    always_comb
    begin
        ks1 = k_slot(ks_reg, 0);
        ks2 = k_slot(ks_reg, 1);
        ks3 = k_slot(ks_reg, 2);
        ko1 = k_slot(ko_reg, 0);
        ko2 = k_slot(ko_reg, 1);
        ko3 = k_slot(ko_reg, 2);
        kn3 = k_slot(kn_reg, 0);
        kn2 = k_slot(kn_reg, 1);
        kno = k_slot(kn_reg, 2);

        div_num[F_S1] = item.substrate_conc;
        div_den[F_S1] = DW'(ks1) + DW'(item.substrate_conc);
        div_num[F_O1] = item.oxygen_conc;
        div_den[F_O1] = DW'(ko1) + DW'(item.oxygen_conc);
        div_num[F_S2] = item.substrate_conc;
        div_den[F_S2] = DW'(ks2) + DW'(item.substrate_conc);
        div_num[F_N3] = item.nitrate_conc;
        div_den[F_N3] = DW'(kn3) + DW'(item.nitrate_conc);
        div_num[F_O2] = CW'(ko2);
        div_den[F_O2] = DW'(ko2) + DW'(item.oxygen_conc);
        div_num[F_S3] = item.substrate_conc;
        div_den[F_S3] = DW'(ks3) + DW'(item.substrate_conc);
        div_num[F_N2] = item.nitrite_conc;
        div_den[F_N2] = DW'(kn2) + DW'(item.nitrite_conc);
        div_num[F_O3] = CW'(ko3);
        div_den[F_O3] = DW'(ko3) + DW'(item.oxygen_conc);
        div_num[F_NO] = CW'(kno);
        div_den[F_NO] = DW'(kno) + DW'(item.nitric_oxide_conc);
    end

    for (genvar i = 0; i < NUM_DIV; i++)
    begin : g_div
        dmr_frac_div u_div (
            .clk (clk),
            .num (div_num[i]),
            .den (div_den[i]),
            .quo (fac[i])
        );
    end

    // biomass and domain flag ride alongside the dividers
    logic [CW-1:0] xd_reg [NS];
    logic [NS-1:0] dd_reg;

    always_ff @(posedge clk)
    begin
        xd_reg[0] <= item.biomass_density;
        for (int i = 1; i < NS; i++)
        begin
            xd_reg[i] <= xd_reg[i-1];
        end
        dd_reg <= {dd_reg[NS-2:0], item.in_domain};
    end

    // rate chain of q16 products, spread over stages a to e
    logic [RW-1:0] r1_a_reg, r2_a_reg, r3_a_reg;
    logic [QW-1:0] fo1_a_reg, fs2_a_reg, fn3_a_reg, fo2_a_reg;
    logic [QW-1:0] fs3_a_reg, fn2_a_reg, fo3_a_reg, fno_a_reg;
    logic [CW-1:0] x_a_reg, x_b_reg, x_c_reg, x_d_reg, x_e_reg;
    logic          d_a_reg, d_b_reg, d_c_reg, d_d_reg, d_e_reg;
    logic [RW-1:0] r1_b_reg, r2_b_reg, r3_b_reg;
    logic [QW-1:0] fn3_b_reg, fo2_b_reg, fn2_b_reg, fo3_b_reg, fno_b_reg;
    logic [RW-1:0] r1_c_reg, r2_c_reg, r3_c_reg;
    logic [QW-1:0] fo2_c_reg, fo3_c_reg, fno_c_reg;
    logic [RW-1:0] r1_d_reg, r2_d_reg, r3_d_reg;
    logic [QW-1:0] fno_d_reg;
    logic [RW-1:0] r1_e_reg, r2_e_reg, r3_e_reg;

    always_ff @(posedge clk)
    begin
        r1_a_reg  <= mul_q16(mu_reg, fac[F_S1]);
        r2_a_reg  <= mul_q16(mu_reg, anox_reg[QW-1:0]);
        r3_a_reg  <= mul_q16(mu_reg, anox_reg[2*QW-1:QW]);
        fo1_a_reg <= fac[F_O1];
        fs2_a_reg <= fac[F_S2];
        fn3_a_reg <= fac[F_N3];
        fo2_a_reg <= fac[F_O2];
        fs3_a_reg <= fac[F_S3];
        fn2_a_reg <= fac[F_N2];
        fo3_a_reg <= fac[F_O3];
        fno_a_reg <= fac[F_NO];
        x_a_reg   <= xd_reg[NS-1];
        d_a_reg   <= dd_reg[NS-1];

        r1_b_reg  <= mul_q16(r1_a_reg, fo1_a_reg);
        r2_b_reg  <= mul_q16(r2_a_reg, fs2_a_reg);
        r3_b_reg  <= mul_q16(r3_a_reg, fs3_a_reg);
        fn3_b_reg <= fn3_a_reg;
        fo2_b_reg <= fo2_a_reg;
        fn2_b_reg <= fn2_a_reg;
        fo3_b_reg <= fo3_a_reg;
        fno_b_reg <= fno_a_reg;
        x_b_reg   <= x_a_reg;
        d_b_reg   <= d_a_reg;

        r1_c_reg  <= r1_b_reg;
        r2_c_reg  <= mul_q16(r2_b_reg, fn3_b_reg);
        r3_c_reg  <= mul_q16(r3_b_reg, fn2_b_reg);
        fo2_c_reg <= fo2_b_reg;
        fo3_c_reg <= fo3_b_reg;
        fno_c_reg <= fno_b_reg;
        x_c_reg   <= x_b_reg;
        d_c_reg   <= d_b_reg;

        r1_d_reg  <= r1_c_reg;
        r2_d_reg  <= mul_q16(r2_c_reg, fo2_c_reg);
        r3_d_reg  <= mul_q16(r3_c_reg, fo3_c_reg);
        fno_d_reg <= fno_c_reg;
        x_d_reg   <= x_c_reg;
        d_d_reg   <= d_c_reg;

        r1_e_reg  <= r1_d_reg;
        r2_e_reg  <= r2_d_reg;
        r3_e_reg  <= mul_q16(r3_d_reg, fno_d_reg);
        x_e_reg   <= x_d_reg;
        d_e_reg   <= d_d_reg;
    end

    // densities and net growth
    logic [RW+1:0]          rsum;
    logic signed [RW+2:0]   ndiff;
    logic signed [RW+2:0]   nhalf;
    logic [dmr_pkg::OUT_W-1:0] net_next;

    always_comb
    begin
        rsum  = (RW+2)'(r1_e_reg) + (RW+2)'(r2_e_reg) + (RW+2)'(r3_e_reg);
        ndiff = $signed({1'b0, rsum}) - $signed((RW+3)'(decay_reg));
        nhalf = ndiff >>> 1;
        // floor halving; only the positive side can overflow
        if (nhalf > $signed((RW+3)'(TCAP)))
        begin
            net_next = dmr_pkg::OUT_W'(TCAP);
        end
        else
        begin
            net_next = nhalf[dmr_pkg::OUT_W-1:0];
        end
    end

    logic [RW-1:0]             rd1_f_reg, rd2_f_reg, rd3_f_reg;
    logic [dmr_pkg::OUT_W-1:0] net_f_reg, net_g_reg, net_h_reg, net_i_reg;
    logic                      d_f_reg, d_g_reg, d_h_reg, d_i_reg;
    logic [V_W-1:0]            v1_g_reg, v23_g_reg, v2_g_reg, v3_g_reg, vall_g_reg;

    always_ff @(posedge clk)
    begin
        rd1_f_reg <= mul_x(r1_e_reg, x_e_reg);
        rd2_f_reg <= mul_x(r2_e_reg, x_e_reg);
        rd3_f_reg <= mul_x(r3_e_reg, x_e_reg);
        net_f_reg <= net_next;
        d_f_reg   <= d_e_reg;

        v1_g_reg   <= V_W'(rd1_f_reg);
        v2_g_reg   <= V_W'(rd2_f_reg);
        v3_g_reg   <= V_W'(rd3_f_reg);
        v23_g_reg  <= V_W'(rd2_f_reg) + V_W'(rd3_f_reg);
        vall_g_reg <= V_W'(rd1_f_reg) + V_W'(rd2_f_reg) + V_W'(rd3_f_reg);
        net_g_reg  <= net_f_reg;
        d_g_reg    <= d_f_reg;
    end

    // coefficient terms split into low 16 and high 33 bit partial products
    logic [PLO_W-1:0] s1_lo_reg, s23_lo_reg, o_lo_reg, a_lo_reg, b_lo_reg, n_p_reg;
    logic [PHI_W-1:0] s1_hi_reg, s23_hi_reg, o_hi_reg, a_hi_reg, b_hi_reg;

    always_ff @(posedge clk)
    begin
        s1_lo_reg  <= PLO_W'(v1_g_reg) * PLO_W'(c_s1_reg[QW-1:0]);
        s1_hi_reg  <= PHI_W'(v1_g_reg) * PHI_W'(c_s1_reg[COEF_W-1:QW]);
        s23_lo_reg <= PLO_W'(v23_g_reg) * PLO_W'(c_s23_reg[QW-1:0]);
        s23_hi_reg <= PHI_W'(v23_g_reg) * PHI_W'(c_s23_reg[COEF_W-1:QW]);
        o_lo_reg   <= PLO_W'(v1_g_reg) * PLO_W'(c_o_reg[QW-1:0]);
        o_hi_reg   <= PHI_W'(v1_g_reg) * PHI_W'(c_o_reg[COEF_W-1:QW]);
        a_lo_reg   <= PLO_W'(v2_g_reg) * PLO_W'(c_a_reg[QW-1:0]);
        a_hi_reg   <= PHI_W'(v2_g_reg) * PHI_W'(c_a_reg[COEF_W-1:QW]);
        b_lo_reg   <= PLO_W'(v3_g_reg) * PLO_W'(c_b_reg[QW-1:0]);
        b_hi_reg   <= PHI_W'(v3_g_reg) * PHI_W'(c_b_reg[COEF_W-1:QW]);
        n_p_reg    <= PLO_W'(vall_g_reg) * PLO_W'(nfrac_reg);
        net_h_reg  <= net_g_reg;
        d_h_reg    <= d_g_reg;
    end

    logic [TW-1:0] ts1_reg, ts23_reg, to_reg, ta_reg, tb_reg, tn_reg;

    always_ff @(posedge clk)
    begin
        ts1_reg   <= term_sat(s1_hi_reg, s1_lo_reg);
        ts23_reg  <= term_sat(s23_hi_reg, s23_lo_reg);
        to_reg    <= term_sat(o_hi_reg, o_lo_reg);
        ta_reg    <= term_sat(a_hi_reg, a_lo_reg);
        tb_reg    <= term_sat(b_hi_reg, b_lo_reg);
        tn_reg    <= term_sat('0, n_p_reg);
        net_i_reg <= net_h_reg;
        d_i_reg   <= d_h_reg;
    end

    // final word
    logic [TW:0]        sub_sum;
    dmr_pkg::out_word_t res_next;
    dmr_pkg::out_word_t result_reg;

    always_comb
    begin
        sub_sum  = (TW+1)'(ts1_reg) + (TW+1)'(ts23_reg);
        res_next = '0;
        res_next.net_growth_rate = net_i_reg;
        if (d_i_reg)
        begin
            res_next.substrate_uptake    = sub_sum[TW] ? $signed({1'b0, TCAP})
                                                       : $signed(sub_sum);
            res_next.oxygen_uptake       = $signed({1'b0, to_reg});
            res_next.nitrate_uptake      = $signed({1'b0, ta_reg});
            res_next.nitrite_uptake      = $signed({1'b0, tb_reg}) - $signed({1'b0, ta_reg});
            res_next.nitric_oxide_uptake = -$signed({1'b0, tb_reg});
            res_next.nitrogen_uptake     = $signed({1'b0, tn_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign result = result_reg;

endmodule

FILE: rtl/core/dmr_checker.sv
module dmr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input dmr_pkg::in_word_t                 item,
    input logic                              done,
    input dmr_pkg::out_word_t                result,
    input logic                              cfg_we,
    input logic [dmr_pkg::CFG_IDX_W-1:0]     cfg_index
);

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(dmr_pkg::LATENCY) done)
        else $error("accepted word did not complete on time");

    // no strobe without a word accepted at the matching edge
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, dmr_pkg::LATENCY))
        else $error("done without an accepted word");

    // a yield or anoxic write starts a coefficient refresh
    a_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == dmr_pkg::CFG_YIELD || cfg_index == dmr_pkg::CFG_ANOXIC)
        |=> busy)
        else $error("coefficient refresh not started");

    // cells outside the mask carry no substrate, oxygen, nitric oxide or nitrogen uptake
    a_masked: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(item.in_domain, dmr_pkg::LATENCY)
        |-> result.substrate_uptake == 0 && result.oxygen_uptake == 0 &&
            result.nitric_oxide_uptake == 0 && result.nitrogen_uptake == 0)
        else $error("uptake outside domain");

endmodule

bind denitrification_monod_rates_core dmr_checker u_dmr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);
